/* hdl/bvnn_pkg.sv */
package bvnn_pkg;

  localparam int MAX_INST   = 256;
  localparam int VEC_WORDS  = 16;
  localparam int LABEL_BITS = 16;

  localparam int WORD_W  = 64;
  localparam int CFG_W   = 5;
  localparam int SCORE_W = 11;
  localparam int PC_W    = 7;
  localparam int INST_W  = $clog2(MAX_INST);
  localparam int CNT_W   = $clog2(MAX_INST + 1);
  localparam int POS_W   = $clog2(VEC_WORDS);
  localparam int VW_W    = $clog2(VEC_WORDS + 1);
  localparam int ADDR_W  = INST_W + POS_W;
  localparam int WMEM_DEPTH = MAX_INST * VEC_WORDS;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_ANSWER  = 2'd0,
    STATUS_STORED  = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_CLEARED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_CHK,
    ST_WORDS,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

/* hdl/bvnn_popcount.sv */
module bvnn_popcount (
  input  logic [bvnn_pkg::WORD_W-1:0] bits,
  output logic [bvnn_pkg::PC_W-1:0]   ones
);

  // Adder tree: each level sums neighbouring partial counts independently.
  logic [1:0] s1 [32];
  logic [2:0] s2 [16];
  logic [3:0] s3 [8];
  logic [4:0] s4 [4];
  logic [5:0] s5 [2];

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      s1[i] = {1'b0, bits[2*i]} + {1'b0, bits[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    end
    ones = {1'b0, s5[0]} + {1'b0, s5[1]};
  end

endmodule

/* hdl/binary_vector_nearest_neighbor_core.sv */
// Binary-vector one-nearest-neighbour classifier. Training vectors and queries arrive one
// 64-bit word per input word, vec_words words to a vector; the label travels with the final
// training word. Every input word that does not complete a vector, and every training or
// clear word, is taken whenever the block is idle and the result register is free or
// being emptied. The final word of a query starts a scan of the stored vectors in load
// order: a vector whose own bit count cannot beat the best score so far is passed over once
// its header is read and checked, and a vector that is scored is read through the single
// read port of the word memory, which delivers one stored word per cycle, after which the
// popcount and accumulate stages must drain before the comparison. No input word is taken
// during the scan. The configuration register is written in one cycle and must only be
// written while the block is idle.
module binary_vector_nearest_neighbor_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bvnn_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          command,
  input  logic [bvnn_pkg::WORD_W-1:0]         word,
  input  logic signed [bvnn_pkg::LABEL_BITS-1:0] label,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output logic signed [bvnn_pkg::LABEL_BITS-1:0] best_label,
  output logic [bvnn_pkg::SCORE_W-1:0]        best_score
);

  // Storage. The word memory holds every stored vector at a fixed stride of VEC_WORDS
  // entries; the header memories hold the label and bit count of each vector.
  logic [bvnn_pkg::WORD_W-1:0]     word_mem  [bvnn_pkg::WMEM_DEPTH];
  logic [bvnn_pkg::LABEL_BITS-1:0] label_mem [bvnn_pkg::MAX_INST];
  logic [bvnn_pkg::SCORE_W-1:0]    count_mem [bvnn_pkg::MAX_INST];
  logic [bvnn_pkg::WORD_W-1:0]     query_mem [bvnn_pkg::VEC_WORDS];

  // Control state.
  bvnn_pkg::state_t           state, state_next;
  logic [bvnn_pkg::CFG_W-1:0] vec_words;
  logic [bvnn_pkg::CNT_W-1:0] instance_count;
  logic [bvnn_pkg::POS_W-1:0] word_position;
  logic [bvnn_pkg::SCORE_W-1:0] load_bit_count;

  // Scan state.
  logic [bvnn_pkg::CNT_W-1:0]      scan_inst;
  logic [bvnn_pkg::POS_W-1:0]      wcnt;
  logic [bvnn_pkg::SCORE_W-1:0]    acc;
  logic [bvnn_pkg::SCORE_W-1:0]    best;
  logic [bvnn_pkg::LABEL_BITS-1:0] best_lbl;
  logic [bvnn_pkg::LABEL_BITS-1:0] cand_label;
  logic                            rd_vld;
  logic                            pc_vld;
  logic [bvnn_pkg::PC_W-1:0]       pc_reg;

  // Registered memory read data.
  logic [bvnn_pkg::WORD_W-1:0]     word_rd;
  logic [bvnn_pkg::WORD_W-1:0]     query_rd;
  logic [bvnn_pkg::LABEL_BITS-1:0] label_rd;
  logic [bvnn_pkg::SCORE_W-1:0]    count_rd;

  // Decoded input word and derived values.
  logic                            accept;
  logic                            room;
  logic                            last;
  logic [bvnn_pkg::VW_W-1:0]       vw;
  logic [bvnn_pkg::PC_W-1:0]       pc_load;
  logic [bvnn_pkg::PC_W-1:0]       pc_scan;
  logic [bvnn_pkg::SCORE_W-1:0]    load_total;
  logic                            out_free;
  logic                            inst_last;
  logic                            words_done;
  logic                            skip;
  logic [bvnn_pkg::ADDR_W-1:0]     store_addr;
  logic [bvnn_pkg::ADDR_W-1:0]     scan_addr;

  assign cfg_ready = 1'b1;

  // A length of zero acts as one word, anything above the capacity as the full length.
  always_comb begin
    if (vec_words == '0) begin
      vw = bvnn_pkg::VW_W'(1);
    end else if (bvnn_pkg::VW_W'(vec_words) > bvnn_pkg::VW_W'(bvnn_pkg::VEC_WORDS)) begin
      vw = bvnn_pkg::VW_W'(bvnn_pkg::VEC_WORDS);
    end else begin
      vw = bvnn_pkg::VW_W'(vec_words);
    end
  end

  bvnn_popcount u_pc_load (
    .bits (word),
    .ones (pc_load)
  );

  bvnn_popcount u_pc_scan (
    .bits (word_rd & query_rd),
    .ones (pc_scan)
  );

  assign out_free   = !out_valid || out_ready;
  assign accept     = in_valid && in_ready;
  assign room       = instance_count < bvnn_pkg::CNT_W'(bvnn_pkg::MAX_INST);
  assign last       = (bvnn_pkg::VW_W'(word_position) + bvnn_pkg::VW_W'(1)) >= vw;
  assign load_total = load_bit_count + bvnn_pkg::SCORE_W'(pc_load);
  assign store_addr = {instance_count[bvnn_pkg::INST_W-1:0], word_position};
  assign scan_addr  = {scan_inst[bvnn_pkg::INST_W-1:0], wcnt};
  assign inst_last  = (scan_inst + bvnn_pkg::CNT_W'(1)) == instance_count;
  assign words_done = (bvnn_pkg::VW_W'(wcnt) + bvnn_pkg::VW_W'(1)) == vw;
  assign skip       = count_rd <= best;

  // Next state and handshake.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      bvnn_pkg::ST_IDLE: begin
        in_ready = out_free;
        if (accept && command == bvnn_pkg::CMD_QUERY && last) begin
          state_next = (instance_count == '0) ? bvnn_pkg::ST_FINISH : bvnn_pkg::ST_HDR;
        end
      end
      bvnn_pkg::ST_HDR: begin
        state_next = bvnn_pkg::ST_CHK;
      end
      bvnn_pkg::ST_CHK: begin
        if (!skip) begin
          state_next = bvnn_pkg::ST_WORDS;
        end else if (inst_last) begin
          state_next = bvnn_pkg::ST_FINISH;
        end else begin
          state_next = bvnn_pkg::ST_HDR;
        end
      end
      bvnn_pkg::ST_WORDS: begin
        if (words_done) begin
          state_next = bvnn_pkg::ST_DRAIN;
        end
      end
      bvnn_pkg::ST_DRAIN: begin
        if (!rd_vld && !pc_vld) begin
          state_next = inst_last ? bvnn_pkg::ST_FINISH : bvnn_pkg::ST_HDR;
        end
      end
      bvnn_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = bvnn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bvnn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bvnn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration, counters and the position within the current vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      vec_words      <= bvnn_pkg::CFG_W'(bvnn_pkg::VEC_WORDS);
      instance_count <= '0;
      word_position  <= '0;
      load_bit_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vec_words <= cfg_data;
      end
      if (accept) begin
        case (command)
          bvnn_pkg::CMD_CLEAR: begin
            instance_count <= '0;
            word_position  <= '0;
            load_bit_count <= '0;
          end
          bvnn_pkg::CMD_STORE: begin
            if (last) begin
              word_position  <= '0;
              load_bit_count <= '0;
              if (room) begin
                instance_count <= instance_count + bvnn_pkg::CNT_W'(1);
              end
            end else begin
              word_position  <= word_position + bvnn_pkg::POS_W'(1);
              load_bit_count <= load_total;
            end
          end
          bvnn_pkg::CMD_QUERY: begin
            if (last) begin
              word_position  <= '0;
              load_bit_count <= '0;
            end else begin
              word_position <= word_position + bvnn_pkg::POS_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (accept && command == bvnn_pkg::CMD_STORE && room) begin
      word_mem[store_addr] <= word;
      if (last) begin
        label_mem[instance_count[bvnn_pkg::INST_W-1:0]] <= label;
        count_mem[instance_count[bvnn_pkg::INST_W-1:0]] <= load_total;
      end
    end
    if (accept && command == bvnn_pkg::CMD_QUERY) begin
      query_mem[word_position] <= word;
    end
  end

  // Memory reads: every port is registered.
  always_ff @(posedge clk) begin
    word_rd  <= word_mem[scan_addr];
    query_rd <= query_mem[wcnt];
    label_rd <= label_mem[scan_inst[bvnn_pkg::INST_W-1:0]];
    count_rd <= count_mem[scan_inst[bvnn_pkg::INST_W-1:0]];
  end

  // Scan datapath: issue a word read, popcount the AND, then accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      pc_vld <= 1'b0;
    end else begin
      rd_vld <= state == bvnn_pkg::ST_WORDS;
      pc_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    pc_reg <= pc_scan;
    if (pc_vld) begin
      acc <= acc + bvnn_pkg::SCORE_W'(pc_reg);
    end
    case (state)
      bvnn_pkg::ST_IDLE: begin
        scan_inst <= '0;
        best      <= '0;
        best_lbl  <= '0;
        wcnt      <= '0;
      end
      bvnn_pkg::ST_CHK: begin
        if (!skip) begin
          cand_label <= label_rd;
          acc        <= '0;
          wcnt       <= '0;
        end else begin
          scan_inst <= scan_inst + bvnn_pkg::CNT_W'(1);
        end
      end
      bvnn_pkg::ST_WORDS: begin
        wcnt <= wcnt + bvnn_pkg::POS_W'(1);
      end
      bvnn_pkg::ST_DRAIN: begin
        if (!rd_vld && !pc_vld) begin
          if (acc > best) begin
            best     <= acc;
            best_lbl <= cand_label;
          end
          scan_inst <= scan_inst + bvnn_pkg::CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: it frees the input side as soon as the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bvnn_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (accept && (command == bvnn_pkg::CMD_CLEAR ||
                            (command == bvnn_pkg::CMD_STORE && last))) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bvnn_pkg::ST_FINISH && out_free) begin
      status     <= bvnn_pkg::STATUS_ANSWER;
      best_label <= best_lbl;
      best_score <= best;
    end else if (accept && command == bvnn_pkg::CMD_CLEAR) begin
      status     <= bvnn_pkg::STATUS_CLEARED;
      best_label <= '0;
      best_score <= '0;
    end else if (accept && command == bvnn_pkg::CMD_STORE && last) begin
      status     <= room ? bvnn_pkg::STATUS_STORED : bvnn_pkg::STATUS_FULL;
      best_label <= '0;
      best_score <= '0;
    end
  end

endmodule

/* hdl/bvnn_checker.sv */
module bvnn_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [1:0]                          status,
  input logic signed [bvnn_pkg::LABEL_BITS-1:0] best_label,
  input logic [bvnn_pkg::SCORE_W-1:0]        best_score
);

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({status, best_label, best_score}))
    else $error("result word changed while stalled");

  // Only a query answer carries a label and a score.
  a_non_answer_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bvnn_pkg::STATUS_ANSWER |-> best_label == '0 && best_score == '0)
    else $error("non-query result carries a label or score");

  // A score can never exceed the bits of a full-length vector.
  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_score <= bvnn_pkg::SCORE_W'(bvnn_pkg::VEC_WORDS * bvnn_pkg::WORD_W))
    else $error("score beyond the vector length");

  // With no positive score there is no nearest vector, so the label is zero.
  a_zero_score_label: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bvnn_pkg::STATUS_ANSWER && best_score == '0 |-> best_label == '0)
    else $error("zero score answered with a non-zero label");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind binary_vector_nearest_neighbor_core bvnn_checker u_bvnn_checker (.*);
